@@ rtl/thermostat_chain_force_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Thermostat chain force unit assertion macros
// Shared concurrent assertion forms that are clocked on clk_i and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef THERMOSTAT_CHAIN_FORCE_UNIT_DEFINES_SVH
`define THERMOSTAT_CHAIN_FORCE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tcf_pkg.sv @@
// ----------------------------------------------------------------------------
// Thermostat chain force package
// Widths, register indexes, transaction types and controller types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcf_pkg;

  localparam int unsigned MaxChain = 8;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CountW   = 13;
  localparam int unsigned ForceW   = 64;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned ProdW    = DataW + CountW;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned DivSteps = 2 * DataW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegTemperature = 1'b0;
  localparam logic [CfgIdxW-1:0] RegCoordCount  = 1'b1;

  // Item kinds.
  localparam logic KindAtom  = 1'b0;
  localparam logic KindChain = 1'b1;

  // Largest value the kinetic accumulator may hold.
  localparam logic [ForceW-1:0] SumMax = {1'b0, {(ForceW-1){1'b1}}};

  typedef struct packed {
    logic                    kind;
    logic signed [DataW-1:0] momentum;
    logic [DataW-1:0]        mass;
    logic                    is_last;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]          chain_index;
    logic signed [ForceW-1:0] force_res;
    logic                     zero_mass;
    logic                     saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StSquare,
    StDivide,
    StAccum,
    StEmit
  } state_e;

  typedef struct packed {
    logic load;
    logic square;
    logic div_step;
    logic accum;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
  } dp_status_t;

endpackage

@@ rtl/tcf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Thermostat chain force controller
// Sequences one transaction through square, divide, accumulate and emit, and
// owns the output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  tcf_pkg::dp_status_t status_i,
  output tcf_pkg::dp_cmd_t    cmd_o
);

  tcf_pkg::state_e              state_q, state_d;
  logic [tcf_pkg::DivCntW-1:0]  cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcf_pkg::StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      tcf_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tcf_pkg::StSquare;
        end
      end
      tcf_pkg::StSquare: begin
        cmd_o.square = 1'b1;
        cnt_d        = '0;
        state_d      = tcf_pkg::StDivide;
      end
      tcf_pkg::StDivide: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == tcf_pkg::DivCntW'(tcf_pkg::DivSteps - 1)) begin
          state_d = tcf_pkg::StAccum;
        end
      end
      tcf_pkg::StAccum: begin
        cmd_o.accum = 1'b1;
        state_d     = tcf_pkg::StEmit;
      end
      tcf_pkg::StEmit: begin
        // A transaction with a result waits until the output register is free.
        if (!status_i.emit) begin
          cmd_o.commit = 1'b1;
          state_d      = tcf_pkg::StIdle;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = tcf_pkg::StIdle;
        end
      end
      default: begin
        state_d = tcf_pkg::StIdle;
      end
    endcase
  end

  assign in_ready_o  = (state_q == tcf_pkg::StIdle);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/tcf_dp.sv @@
// ----------------------------------------------------------------------------
// Thermostat chain force datapath
// Squarer, radix-2 restoring divider, saturating kinetic accumulator, chain
// position tracking and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcf_dp #(
  parameter int unsigned MAX_CHAIN = tcf_pkg::MaxChain
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcf_pkg::dp_cmd_t            cmd_i,
  output tcf_pkg::dp_status_t         status_o,
  input  tcf_pkg::in_item_t           in_data_i,
  input  logic [tcf_pkg::DataW-1:0]   temperature_i,
  input  logic [tcf_pkg::ProdW-1:0]   coord_temp_i,
  output tcf_pkg::out_item_t          out_data_o
);

  localparam int unsigned PosW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
  localparam int unsigned DW   = tcf_pkg::DataW;
  localparam int unsigned FW   = tcf_pkg::ForceW;

  tcf_pkg::in_item_t   item_q;
  tcf_pkg::out_item_t  out_q;
  logic [DW-1:0]       rem_q;
  logic [FW-1:0]       dq_q;
  logic [FW-1:0]       sum_q;
  logic [1:0]          flags_q;
  logic [PosW-1:0]     pos_q;

  logic [DW-1:0]       mom_u;
  logic [DW-1:0]       mag;
  logic [FW-1:0]       sq;
  logic [DW:0]         shifted;
  logic [DW+1:0]       diff;
  logic                ge;
  logic                zm;
  logic [FW-1:0]       term;
  logic [FW-1:0]       sum_add;
  logic                sat;
  logic [PosW:0]       pos_inc;
  logic [PosW+2:0]     idx_ext;
  logic                drop;
  logic                emit;

  // Magnitude of the momentum; the most negative value maps to 2^31.
  assign mom_u = item_q.momentum;
  assign mag   = mom_u[DW-1] ? (~mom_u + 1'b1) : mom_u;
  assign sq    = mag * mag;

  // One restoring step: the partial remainder takes the next dividend bit.
  assign shifted = {rem_q, dq_q[FW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, item_q.mass};
  assign ge      = !diff[DW+1];

  assign zm   = (item_q.mass == '0);
  assign term = zm ? '0 : dq_q;

  // Both operands stay below 2^63, so bit 63 of the sum flags overflow.
  assign sum_add = sum_q + term;
  assign sat     = sum_add[FW-1];

  assign pos_inc = {1'b0, pos_q} + 1'b1;
  assign idx_ext = (PosW + 3)'(pos_inc);
  assign drop    = (pos_inc >= (PosW + 1)'(MAX_CHAIN));
  assign emit    = (item_q.kind == tcf_pkg::KindAtom) ? item_q.is_last : !drop;

  assign status_o.emit = emit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.square) begin
      dq_q  <= sq;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q  <= {dq_q[FW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
    end
    if (cmd_i.commit && emit) begin
      if (item_q.kind == tcf_pkg::KindAtom) begin
        out_q.chain_index <= '0;
        out_q.force_res   <= sum_q - FW'(coord_temp_i);
        out_q.zero_mass   <= flags_q[0];
        out_q.saturated   <= flags_q[1];
      end else begin
        out_q.chain_index <= idx_ext[tcf_pkg::IdxW-1:0];
        out_q.force_res   <= term - FW'(temperature_i);
        out_q.zero_mass   <= zm;
        out_q.saturated   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      flags_q <= '0;
      pos_q   <= '0;
    end else if (cmd_i.accum && (item_q.kind == tcf_pkg::KindAtom)) begin
      sum_q   <= sat ? tcf_pkg::SumMax : sum_add;
      flags_q <= flags_q | {sat, zm};
    end else if (cmd_i.commit) begin
      if (item_q.kind == tcf_pkg::KindAtom) begin
        if (item_q.is_last) begin
          sum_q   <= '0;
          flags_q <= '0;
          pos_q   <= '0;
        end
      end else if (item_q.is_last) begin
        pos_q <= '0;
      end else if (!drop) begin
        pos_q <= pos_inc[PosW-1:0];
      end
    end
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/thermostat_chain_force_unit.sv @@
// ----------------------------------------------------------------------------
// Thermostat chain force unit: processes one transaction at a time.
// A result is registered in the emit step, after square, divide and accumulate.
// Async reset clears sum, flags, chain position, config and handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "thermostat_chain_force_unit_defines.svh"

// Each input transaction carries a momentum and a mass, tagged as an atom
// coordinate or a thermostat chain element. The kinetic term momentum^2/mass
// is formed by a 32x32 squarer followed by a radix-2 restoring divider that
// retires one quotient bit per cycle into a 64-bit quotient. Atom terms
// are summed into a saturating accumulator; the last atom transaction reports
// chain force 0 as the sum minus coord_count times temperature. Chain
// transactions report force k+1 as the term minus temperature, up to
// MAX_CHAIN-1 forces per chain.
//
// The controller accepts a new input transaction whenever it is idle, even
// while a finished result still sits in the output register. A transaction
// that produces a result waits in its final step only if the output register
// is still occupied by the previous, untaken result.

module thermostat_chain_force_unit #(
  parameter int unsigned MAX_CHAIN = tcf_pkg::MaxChain
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input transactions
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tcf_pkg::in_item_t             in_data_i,
  // Result transactions
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tcf_pkg::out_item_t            out_data_o,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [tcf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tcf_pkg::DataW-1:0]     cfg_data_i
);

  logic [tcf_pkg::DataW-1:0]  temperature_q;
  logic [tcf_pkg::CountW-1:0] coord_count_q;
  logic [tcf_pkg::ProdW-1:0]  coord_temp_q, coord_temp_d;

  tcf_pkg::dp_cmd_t    cmd;
  tcf_pkg::dp_status_t status;

  // Configuration registers. The user must make writes only while the unit is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temperature_q <= '0;
      coord_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcf_pkg::RegTemperature: begin
          temperature_q <= cfg_data_i;
        end
        tcf_pkg::RegCoordCount: begin
          coord_count_q <= cfg_data_i[tcf_pkg::CountW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The coord_count * temperature offset is refreshed every cycle. After a
  // configuration write it passes through the configuration register and then
  // coord_temp_q, long before any following transaction reaches the point where it is used.
  assign coord_temp_d = temperature_q * coord_count_q;

  always_ff @(posedge clk_i) begin
    coord_temp_q <= coord_temp_d;
  end

  tcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcf_dp #(
    .MAX_CHAIN (MAX_CHAIN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_data_i     (in_data_i),
    .temperature_i (temperature_q),
    .coord_temp_i  (coord_temp_q),
    .out_data_o    (out_data_o)
  );

  // Only the atom sum can saturate; chain forces never report it.
  `TCF_ASSERT_SAME(a_chain_not_saturated, out_valid_o && (out_data_o.chain_index != '0), !out_data_o.saturated, "chain force reported as saturated")
  // An accepted transaction keeps the unit busy in the following cycle.
  `TCF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "unit ready right after an accept")
  // A result cannot appear in the cycle right after a transaction was accepted.
  `TCF_ASSERT_NEXT(a_no_result_after_accept, in_valid_i && in_ready_o, !$rose(out_valid_o), "result raised right after an accept")

endmodule

@@ dv/thermostat_chain_force_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Thermostat chain force unit testbench
// Sends atom and chain transactions through the unit, predicts each chain
// force in fixed point alongside it and compares every result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thermostat_chain_force_unit_tb;
  import tcf_pkg::*;

  // The watchdog guards a run of about 1700 transactions against a hung
  // handshake.
  localparam int CycleLimit  = 1_000_000;
  // This covers an item that is still in the divider and will not produce
  // a result.
  localparam int DrainCycles = 80;
  localparam int PhaseItems  = 540;
  localparam logic [DataW-1:0] MomMinNeg = 32'h8000_0000;
  localparam logic [DataW-1:0] MomMaxPos = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] WordMax   = 32'hFFFF_FFFF;
  localparam logic [DataW-1:0] QOne      = 32'h0001_0000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = RegTemperature;
  logic [DataW-1:0]   cfg_data_i  = '0;

  thermostat_chain_force_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Shadow copy of the unit's registers and accumulator state. It is updated
  // at the edge where the unit takes each write or transaction.
  logic [DataW-1:0]  temp_reg    = '0;
  logic [CountW-1:0] coord_reg   = '0;
  logic [ForceW-1:0] kin_sum     = '0;
  int unsigned       chain_pos   = 0;
  logic              sticky_zero = 1'b0;
  logic              sticky_sat  = 1'b0;

  out_item_t expected_forces[$];
  out_item_t oldest_force;
  int        failures      = 0;
  int        cycle_count   = 0;
  int        useful_items  = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        stall_left    = 0;

  // Computes the force that one transaction produces, if any, and advances
  // the shadow state. The kinetic term is momentum squared (exact, as Q32.32)
  // divided by the Q16.16 mass, truncated; a zero mass forces the term to 0.
  function automatic bit predict_force(input in_item_t item, output out_item_t res);
    logic [DataW:0]    mag;
    logic [ForceW-1:0] term;
    logic              zm;
    mag  = item.momentum[DataW-1] ? ({1'b1, {DataW{1'b0}}} - {1'b0, item.momentum})
                                  : {1'b0, item.momentum};
    zm   = (item.mass == '0);
    term = zm ? '0 : (64'(mag) * 64'(mag)) / 64'(item.mass);
    res  = '0;
    if (item.kind == KindAtom) begin
      sticky_zero |= zm;
      if (term > SumMax - kin_sum) begin
        kin_sum    = SumMax;
        sticky_sat = 1'b1;
      end else begin
        kin_sum += term;
      end
      if (!item.is_last) return 1'b0;
      // The last atom closes the sum: force 0 is the kinetic sum minus the
      // thermal energy of all degrees of freedom. The chain restarts too.
      res.chain_index = '0;
      res.force_res   = kin_sum - 64'(coord_reg) * 64'(temp_reg);
      res.zero_mass   = sticky_zero;
      res.saturated   = sticky_sat;
      kin_sum     = '0;
      sticky_zero = 1'b0;
      sticky_sat  = 1'b0;
      chain_pos   = 0;
      return 1'b1;
    end
    // A chain that runs past the last force slot is dropped silently; its
    // last element still brings the position back to the start.
    if (chain_pos + 1 >= MaxChain) begin
      if (item.is_last) chain_pos = 0;
      return 1'b0;
    end
    res.chain_index = IdxW'(chain_pos + 1);
    res.force_res   = term - 64'(temp_reg);
    res.zero_mass   = zm;
    res.saturated   = 1'b0;
    chain_pos = item.is_last ? 0 : chain_pos + 1;
    return 1'b1;
  endfunction

  // Offers one transaction, after an optional random gap, and holds it until
  // the unit takes it. Valid stays high on return so that back-to-back
  // transactions never lower and raise it within one time step.
  task automatic send_item(input in_item_t item);
    out_item_t res;
    bit        produces;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    produces = predict_force(item, res);
    if (produces) expected_forces.push_back(res);
    // Overflow chain items are ignored by the unit and do not count.
    if (produces || item.kind == KindAtom) useful_items++;
  endtask

  function automatic in_item_t make_item(input logic kind, input logic last,
                                         input logic [DataW-1:0] mom,
                                         input logic [DataW-1:0] mass);
    in_item_t item;
    item.kind     = kind;
    item.momentum = mom;
    item.mass     = mass;
    item.is_last  = last;
    return item;
  endfunction

  // Stops offering, waits for every predicted result to come out and then
  // for the divider to finish any transaction that yields no result.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes both registers on consecutive edges; call only while idle.
  task automatic configure(input logic [DataW-1:0] temp, input logic [CountW-1:0] coord);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegTemperature;
    cfg_data_i <= temp;
    @(posedge clk_i);
    temp_reg   = temp;
    cfg_idx_i  <= RegCoordCount;
    cfg_data_i <= DataW'(coord);
    @(posedge clk_i);
    coord_reg  = coord;
    cfg_we_i   <= 1'b0;
  endtask

  // Random field values, weighted toward the corners: extreme momenta, zero
  // and full-scale masses, plus a heavy mode that drives the sum to saturation.
  function automatic in_item_t random_item(input logic kind, input logic last,
                                           input bit heavy);
    logic [DataW-1:0] mom;
    logic [DataW-1:0] mass;
    int               sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      case ($urandom_range(3))
        0:       mom = MomMinNeg;
        1:       mom = MomMaxPos;
        2:       mom = '0;
        default: mom = WordMax;
      endcase
    end else if (sel < 5) begin
      mom = $urandom;
    end else begin
      mom = DataW'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    end
    sel = $urandom_range(19);
    if (sel == 0)      mass = '0;
    else if (sel < 3)  mass = $urandom;
    else if (sel == 3) mass = WordMax;
    else               mass = $urandom_range(1, 32'h0010_0000);
    if (heavy) begin
      mom  = $urandom_range(1) ? MomMinNeg : (32'h7FFF_0000 | DataW'($urandom_range(16'hFFFF)));
      mass = $urandom_range(1, 4);
    end
    return make_item(kind, last, mom, mass);
  endfunction

  // One burst of traffic: mostly a whole atom sweep or a whole chain, with
  // random content, and now and then a lone random transaction as noise.
  task automatic send_random_burst();
    int sel;
    int len;
    bit heavy;
    sel = $urandom_range(99);
    if (sel < 45) begin
      len   = $urandom_range(1, 10);
      heavy = ($urandom_range(7) == 0);
      for (int i = 0; i < len; i++) send_item(random_item(KindAtom, i == len - 1, heavy));
    end else if (sel < 85) begin
      // Up to nine elements so that some chains overflow the force slots.
      len = $urandom_range(1, 9);
      for (int i = 0; i < len; i++) send_item(random_item(KindChain, i == len - 1, 1'b0));
    end else begin
      send_item(random_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                            $urandom_range(3) == 0));
    end
  endtask

  // Directed corners: saturation of the sum, zero masses, extreme momenta,
  // the full and overflowing chain, a chain cut short by an atom sweep, and
  // the extremes of both registers.
  task automatic test_directed();
    configure(WordMax, 13'd4096);
    send_item(make_item(KindAtom, 1'b0, MomMinNeg, 32'd1));
    send_item(make_item(KindAtom, 1'b0, MomMinNeg, 32'd1));
    send_item(make_item(KindAtom, 1'b0, MomMaxPos, WordMax));
    send_item(make_item(KindAtom, 1'b1, '0, '0));
    send_item(make_item(KindAtom, 1'b1, WordMax, QOne));
    // Eight chain elements without an end: seven forces, then one dropped.
    for (int i = 0; i < 8; i++) begin
      send_item(make_item(KindChain, 1'b0, (i % 2) ? MomMinNeg : MomMaxPos,
                          (i == 3) ? '0 : DataW'(i + 1) << 14));
    end
    send_item(make_item(KindChain, 1'b1, QOne, QOne));
    send_item(make_item(KindChain, 1'b1, 32'hFFFE_0000, '0));
    send_item(make_item(KindChain, 1'b1, MomMaxPos, 32'd1));
    drain_results();
    configure('0, '0);
    send_item(make_item(KindAtom, 1'b1, MomMinNeg, WordMax));
    send_item(make_item(KindChain, 1'b0, 32'h1234_5678, '0));
    send_item(make_item(KindAtom, 1'b1, 32'h0003_0000, QOne));
    send_item(make_item(KindChain, 1'b0, 32'hDEAD_BEEF, 32'hFFFF_0000));
    drain_results();
    configure(QOne, 13'h1FFF);
    send_item(make_item(KindAtom, 1'b1, 32'h0002_0000, QOne));
    send_item(make_item(KindChain, 1'b1, 32'h0000_8000, 32'h0000_4000));
    drain_results();
  endtask

  // Random traffic under one idling pattern, split into four register
  // settings. The register values lean toward the extremes.
  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    int               target;
    logic [DataW-1:0] temp;
    logic [CountW-1:0] coord;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int part = 0; part < 4; part++) begin
      drain_results();
      case ($urandom_range(3))
        0:       temp = '0;
        1:       temp = WordMax;
        2:       temp = $urandom_range(0, 32'h0040_0000);
        default: temp = $urandom;
      endcase
      case ($urandom_range(3))
        0:       coord = '0;
        1:       coord = 13'h1FFF;
        2:       coord = 13'd4096;
        default: coord = CountW'($urandom);
      endcase
      configure(temp, coord);
      target = useful_items + PhaseItems / 4;
      while (useful_items < target) send_random_burst();
    end
  endtask

  // The receiver stops for a long stretch while transactions keep coming, so
  // the output register fills, the unit parks in its final step and its
  // input stalls. Each transaction here yields a result.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_results();
    stall_left = 600;
    send_item(make_item(KindAtom, 1'b1, 32'h0005_0000, QOne));
    for (int i = 0; i < 5; i++) send_item(random_item(KindChain, i == 4, 1'b0));
    drain_results();
  endtask

  // Receiver side: random stalls at the current rate, or a counted stretch
  // of held-off cycles when one is requested.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  = stall_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every result transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_forces.size() == 0) begin
        $error("unexpected result: chain_index %0d force_res %0d",
               out_data_o.chain_index, out_data_o.force_res);
        failures++;
      end else begin
        oldest_force = expected_forces.pop_front();
        if (out_data_o.chain_index !== oldest_force.chain_index) begin
          $error("chain_index: expected %0d, actual %0d",
                 oldest_force.chain_index, out_data_o.chain_index);
          failures++;
        end
        if (out_data_o.force_res !== oldest_force.force_res) begin
          $error("force_res: expected %0d, actual %0d",
                 oldest_force.force_res, out_data_o.force_res);
          failures++;
        end
        if (out_data_o.zero_mass !== oldest_force.zero_mass) begin
          $error("zero_mass: expected %0b, actual %0b",
                 oldest_force.zero_mass, out_data_o.zero_mass);
          failures++;
        end
        if (out_data_o.saturated !== oldest_force.saturated) begin
          $error("saturated: expected %0b, actual %0b",
                 oldest_force.saturated, out_data_o.saturated);
          failures++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("thermostat_chain_force_unit_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic(21, 58);
    test_random_traffic(58, 21);
    test_random_traffic(0, 0);
    test_backpressure();
    // Anything left in the queue at this point is a missing result.
    if (expected_forces.size() != 0) begin
      $error("%0d expected results never arrived", expected_forces.size());
      failures++;
    end
    if (failures == 0) begin
      $display("thermostat_chain_force_unit_tb passed");
    end else begin
      $display("thermostat_chain_force_unit_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tcf_pkg.sv
rtl/tcf_ctrl.sv
rtl/tcf_dp.sv
rtl/thermostat_chain_force_unit.sv
dv/thermostat_chain_force_unit_tb.sv
